[rtl/core/packet_sequence_reorder_buffer_unit_macros.svh]
// assertion helpers for the reorder buffer
`ifndef PACKET_SEQUENCE_REORDER_BUFFER_UNIT_MACROS_SVH
`define PACKET_SEQUENCE_REORDER_BUFFER_UNIT_MACROS_SVH

// condition that holds at every edge outside reset
`define PSRB_ASSERT_ALWAYS(lbl, clk_s, rstn_s, expr) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (expr)) \
        else $error("reorder buffer invariant violated");

// same-cycle implication outside reset
`define PSRB_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("reorder buffer implication violated");

`endif

[rtl/core/psrb_pkg.sv]
package psrb_pkg;

    // field widths
    localparam int SEQ_W = 16;
    localparam int TAG_W = 16;
    localparam int EV_W  = 3;
    localparam int LIM_W = 6;

    // window store, depth must be a power of two
    localparam int WINDOW_DEPTH = 64;
    localparam int IDX_W        = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = IDX_W + 1;

    localparam logic [LIM_W-1:0] HOLD_LIMIT_RESET = LIM_W'(63);

    // result event codes
    typedef enum logic [EV_W-1:0] {
        EV_RELEASED = 3'd0,
        EV_HEADER   = 3'd1,
        EV_LATE     = 3'd2,
        EV_OUTSIDE  = 3'd3,
        EV_RESYNC   = 3'd4
    } ev_t;

    // packet classes found in the classify step
    typedef enum logic [2:0] {
        CL_HDR,
        CL_BASE,
        CL_LATE,
        CL_FAR,
        CL_NEXT,
        CL_DUP,
        CL_EARLY
    } class_t;

    // microprogram steps
    typedef enum logic [2:0] {
        U_IDLE,
        U_CLASS,
        U_ONE,
        U_STORE,
        U_RESYNC,
        U_RELEASE,
        U_DRAIN
    } upc_t;

    // datapath actions
    typedef enum logic [2:0] {
        A_LOAD,
        A_CLASSIFY,
        A_ONE,
        A_STORE,
        A_RESYNC,
        A_RELEASE,
        A_DRAIN
    } act_t;

    // jump conditions
    typedef enum logic [2:0] {
        C_ALWAYS,
        C_IN,
        C_DISPATCH,
        C_LIMIT,
        C_MORE
    } cond_t;

    // one control word
    typedef struct packed {
        act_t  act;
        logic  wait_out;
        cond_t cond;
        upc_t  tgt_t;
        upc_t  tgt_f;
    } ctrl_t;

    // control store
    function automatic ctrl_t psrb_rom(input upc_t step);
        ctrl_t cw;
        cw = '{act: A_LOAD, wait_out: 1'b0, cond: C_IN, tgt_t: U_CLASS, tgt_f: U_IDLE};
        case (step)
            U_IDLE:
                cw = '{act: A_LOAD, wait_out: 1'b0, cond: C_IN,
                       tgt_t: U_CLASS, tgt_f: U_IDLE};
            U_CLASS:
                cw = '{act: A_CLASSIFY, wait_out: 1'b0, cond: C_DISPATCH,
                       tgt_t: U_ONE, tgt_f: U_ONE};
            U_ONE:
                cw = '{act: A_ONE, wait_out: 1'b1, cond: C_ALWAYS,
                       tgt_t: U_IDLE, tgt_f: U_IDLE};
            U_STORE:
                cw = '{act: A_STORE, wait_out: 1'b0, cond: C_LIMIT,
                       tgt_t: U_RESYNC, tgt_f: U_IDLE};
            U_RESYNC:
                cw = '{act: A_RESYNC, wait_out: 1'b1, cond: C_ALWAYS,
                       tgt_t: U_IDLE, tgt_f: U_IDLE};
            U_RELEASE:
                cw = '{act: A_RELEASE, wait_out: 1'b1, cond: C_MORE,
                       tgt_t: U_DRAIN, tgt_f: U_IDLE};
            U_DRAIN:
                cw = '{act: A_DRAIN, wait_out: 1'b1, cond: C_MORE,
                       tgt_t: U_DRAIN, tgt_f: U_IDLE};
            default:
                cw = '{act: A_LOAD, wait_out: 1'b0, cond: C_IN,
                       tgt_t: U_CLASS, tgt_f: U_IDLE};
        endcase
        return cw;
    endfunction

    // dispatch table of the classify step
    function automatic upc_t psrb_dispatch(input class_t cls);
        upc_t tgt;
        case (cls)
            CL_NEXT:  tgt = U_RELEASE;
            CL_EARLY: tgt = U_STORE;
            default:  tgt = U_ONE;
        endcase
        return tgt;
    endfunction

    // event of a single-result class
    function automatic ev_t psrb_class_event(input class_t cls);
        ev_t ev;
        case (cls)
            CL_HDR:  ev = EV_HEADER;
            CL_LATE: ev = EV_LATE;
            CL_DUP:  ev = EV_LATE;
            CL_FAR:  ev = EV_OUTSIDE;
            default: ev = EV_RELEASED;
        endcase
        return ev;
    endfunction

endpackage

[rtl/core/psrb_if.sv]
// packet item channel
interface psrb_pkt_if;
    import psrb_pkg::*;

    logic             valid;
    logic             ready;
    logic [SEQ_W-1:0] seq_number;
    logic [TAG_W-1:0] payload_tag;

    modport source (output valid, output seq_number, output payload_tag, input ready);
    modport sink   (input valid, input seq_number, input payload_tag, output ready);
endinterface

// result item channel
interface psrb_res_if;
    import psrb_pkg::*;

    logic             valid;
    logic             ready;
    logic [EV_W-1:0]  event_res;
    logic [SEQ_W-1:0] out_seq;
    logic [TAG_W-1:0] out_tag;
    logic             last;

    modport source (output valid, output event_res, output out_seq, output out_tag,
                    output last, input ready);
    modport sink   (input valid, input event_res, input out_seq, input out_tag,
                    input last, output ready);
endinterface

// hold limit write channel
interface psrb_cfg_if;
    import psrb_pkg::*;

    logic             valid;
    logic             ready;
    logic [LIM_W-1:0] hold_limit;

    modport source (output valid, output hold_limit, input ready);
    modport sink   (input valid, input hold_limit, output ready);
endinterface

[rtl/core/packet_sequence_reorder_buffer_unit.sv]
// results: an item is classified after it is accepted, then its first result is registered in
//   the one-result or release step, or in the resync step when the store overflows; a stalled result
//   output holds the step. A new item is taken only in the idle step, after the last one is done;
//   the drain reads one slot per cycle from the tag memory read port unless output stalls
// reset: sequencer idle, no baseline, all slot valid bits and the held count cleared,
//   hold limit 63; the tag memory is not cleared
`include "packet_sequence_reorder_buffer_unit_macros.svh"

module packet_sequence_reorder_buffer_unit (
    input logic      clk,
    input logic      rst_n,
    psrb_pkt_if.sink pkt,
    psrb_res_if.source res,
    psrb_cfg_if.sink cfg
);
    import psrb_pkg::*;

    // sequencer
    upc_t  upc_reg;
    upc_t  upc_next;
    ctrl_t cw;
    logic  fire;
    logic  cond_c;

    // datapath state
    logic [LIM_W-1:0]        limit_reg;
    logic                    synced_reg;
    logic [SEQ_W-1:0]        last_reg;
    logic [SEQ_W-1:0]        seq_reg;
    logic [TAG_W-1:0]        tag_reg;
    logic [TAG_W-1:0]        rd_tag_reg;
    logic [WINDOW_DEPTH-1:0] valid_reg;
    logic [TAG_W-1:0]        tag_mem [WINDOW_DEPTH];
    logic [IDX_W-1:0]        head_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [CNT_W-1:0]        held_reg;
    logic [IDX_W-1:0]        n_reg;
    class_t                  class_reg;

    // result register
    logic             out_valid_reg;
    ev_t              out_ev_reg;
    logic [SEQ_W-1:0] out_seq_reg;
    logic [TAG_W-1:0] out_tag_reg;
    logic             out_last_reg;

    // datapath helpers
    logic             out_free;
    logic [SEQ_W-1:0] dist_c;
    logic [IDX_W-1:0] idx_c;
    logic [IDX_W-1:0] head_inc;
    logic [SEQ_W-1:0] next_seq;
    logic [CNT_W-1:0] held_inc;
    logic             limit_c;
    logic             more_c;
    class_t           class_c;

    assign cw       = psrb_rom(upc_reg);
    assign out_free = !out_valid_reg || res.ready;
    assign fire     = !cw.wait_out || out_free;

    // distance and window slot of the current packet
    assign dist_c   = seq_reg - last_reg;
    assign idx_c    = IDX_W'(head_reg + dist_c[IDX_W-1:0] - IDX_W'(1));
    assign head_inc = IDX_W'(head_reg + IDX_W'(1));
    assign next_seq = SEQ_W'(last_reg + SEQ_W'(1));
    assign held_inc = CNT_W'(held_reg + CNT_W'(1));
    assign limit_c  = held_inc > CNT_W'(limit_reg);

    // another held packet follows, capped at the result budget of one item
    assign more_c = valid_reg[head_inc] &&
                    ((cw.act != A_DRAIN) || (n_reg != IDX_W'(WINDOW_DEPTH - 1)));

    // packet classification
    always_comb
    begin
        if (seq_reg == '0)
            class_c = CL_HDR;
        else if (!synced_reg)
            class_c = CL_BASE;
        else if ((dist_c == '0) || dist_c[SEQ_W-1])
            class_c = CL_LATE;
        else if (dist_c > SEQ_W'(WINDOW_DEPTH))
            class_c = CL_FAR;
        else if (dist_c == SEQ_W'(1))
            class_c = CL_NEXT;
        else if (valid_reg[idx_c])
            class_c = CL_DUP;
        else
            class_c = CL_EARLY;
    end

    // jump condition
    always_comb
    begin
        case (cw.cond)
            C_ALWAYS:   cond_c = 1'b1;
            C_IN:       cond_c = pkt.valid;
            C_DISPATCH: cond_c = 1'b1;
            C_LIMIT:    cond_c = limit_c;
            C_MORE:     cond_c = more_c;
            default:    cond_c = 1'b0;
        endcase
    end

    // next step
    always_comb
    begin
        if (!fire)
            upc_next = upc_reg;
        else if (cw.cond == C_DISPATCH)
            upc_next = psrb_dispatch(class_c);
        else if (cond_c)
            upc_next = cw.tgt_t;
        else
            upc_next = cw.tgt_f;
    end

    // handshakes
    assign pkt.ready     = (cw.act == A_LOAD);
    assign cfg.ready     = 1'b1;
    assign res.valid     = out_valid_reg;
    assign res.event_res = out_ev_reg;
    assign res.out_seq   = out_seq_reg;
    assign res.out_tag   = out_tag_reg;
    assign res.last      = out_last_reg;

    // sequencer, datapath state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= U_IDLE;
            limit_reg     <= HOLD_LIMIT_RESET;
            synced_reg    <= 1'b0;
            last_reg      <= '0;
            seq_reg       <= '0;
            tag_reg       <= '0;
            valid_reg     <= '0;
            head_reg      <= '0;
            idx_reg       <= '0;
            held_reg      <= '0;
            n_reg         <= '0;
            class_reg     <= CL_HDR;
            out_valid_reg <= 1'b0;
            out_ev_reg    <= EV_RELEASED;
            out_seq_reg   <= '0;
            out_tag_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            upc_reg <= upc_next;

            if (res.ready)
                out_valid_reg <= 1'b0;

            if (cfg.valid)
                limit_reg <= cfg.hold_limit;

            if (fire)
            begin
                case (cw.act)
                    A_LOAD:
                    begin
                        if (pkt.valid)
                        begin
                            seq_reg <= pkt.seq_number;
                            tag_reg <= pkt.payload_tag;
                        end
                    end
                    A_CLASSIFY:
                    begin
                        class_reg <= class_c;
                        idx_reg   <= idx_c;
                    end
                    A_ONE:
                    begin
                        out_valid_reg <= 1'b1;
                        out_ev_reg    <= psrb_class_event(class_reg);
                        out_seq_reg   <= seq_reg;
                        out_tag_reg   <= tag_reg;
                        out_last_reg  <= 1'b1;
                        // baseline restarts an empty window
                        if (class_reg == CL_BASE)
                        begin
                            valid_reg  <= '0;
                            held_reg   <= '0;
                            head_reg   <= '0;
                            synced_reg <= 1'b1;
                            last_reg   <= seq_reg;
                        end
                    end
                    A_STORE:
                    begin
                        valid_reg[idx_reg] <= 1'b1;
                        held_reg           <= held_inc;
                    end
                    A_RESYNC:
                    begin
                        valid_reg     <= '0;
                        held_reg      <= '0;
                        head_reg      <= '0;
                        synced_reg    <= 1'b0;
                        out_valid_reg <= 1'b1;
                        out_ev_reg    <= EV_RESYNC;
                        out_seq_reg   <= seq_reg;
                        out_tag_reg   <= tag_reg;
                        out_last_reg  <= 1'b1;
                    end
                    A_RELEASE:
                    begin
                        out_valid_reg <= 1'b1;
                        out_ev_reg    <= EV_RELEASED;
                        out_seq_reg   <= next_seq;
                        out_tag_reg   <= tag_reg;
                        out_last_reg  <= !more_c;
                        last_reg      <= next_seq;
                        head_reg      <= head_inc;
                        n_reg         <= IDX_W'(1);
                    end
                    A_DRAIN:
                    begin
                        out_valid_reg       <= 1'b1;
                        out_ev_reg          <= EV_RELEASED;
                        out_seq_reg         <= next_seq;
                        out_tag_reg         <= rd_tag_reg;
                        out_last_reg        <= !more_c;
                        valid_reg[head_reg] <= 1'b0;
                        if (held_reg != '0)
                            held_reg <= CNT_W'(held_reg - CNT_W'(1));
                        last_reg <= next_seq;
                        head_reg <= head_inc;
                        n_reg    <= IDX_W'(n_reg + IDX_W'(1));
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // tag memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (fire && (cw.act == A_STORE))
            tag_mem[idx_reg] <= tag_reg;
        if (fire && ((cw.act == A_RELEASE) || (cw.act == A_DRAIN)))
            rd_tag_reg <= tag_mem[head_inc];
    end

    // checks
    `PSRB_ASSERT_ALWAYS(a_held_matches_valid, clk, rst_n, $countones(valid_reg) == held_reg)
    `PSRB_ASSERT_IMPL(a_unsynced_empty, clk, rst_n, !synced_reg, held_reg == '0)
    `PSRB_ASSERT_IMPL(a_open_drain, clk, rst_n, out_valid_reg && !out_last_reg, upc_reg == U_DRAIN)
    `PSRB_ASSERT_IMPL(a_drain_slot_held, clk, rst_n, upc_reg == U_DRAIN, valid_reg[head_reg])

endmodule

[test/packet_sequence_reorder_buffer_unit_test.sv]
`timescale 1ns / 1ps

module packet_sequence_reorder_buffer_unit_test;
    import psrb_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT   = 2000;
    localparam int REPORT_LIMIT  = 40;
    localparam int PHASE_COUNT   = 7;
    localparam int PHASE_ITEMS   = 45;
    localparam int NOISE_PCT     = 18;
    localparam int BASE_SEQ_MAX  = 60000;

    // hold limit of each random phase, extremes included
    localparam int PHASE_LIMIT [PHASE_COUNT] = '{1, 63, 0, 20, 63, 5, 40};
    // idling modes: none, sender, receiver, both
    localparam int SEND_IDLE [4]  = '{0, 70, 0, 26};
    localparam int RECV_STALL [4] = '{0, 0, 70, 26};

    typedef struct {
        logic [SEQ_W-1:0] seq;
        logic [TAG_W-1:0] tag;
    } packet_t;

    typedef struct {
        ev_t              ev;
        logic [SEQ_W-1:0] seq;
        logic [TAG_W-1:0] tag;
        logic             last;
    } outcome_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    psrb_pkt_if pkt ();
    psrb_res_if res ();
    psrb_cfg_if cfg ();

    packet_sequence_reorder_buffer_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pkt   (pkt),
        .res   (res),
        .cfg   (cfg)
    );

    // predicted buffer state
    logic             synced_q;
    logic [SEQ_W-1:0] released_seq;
    logic [IDX_W-1:0] head_idx;
    logic [CNT_W-1:0] held_cnt;
    logic [LIM_W-1:0] limit_q;
    logic             held_valid [WINDOW_DEPTH];
    logic [TAG_W-1:0] held_tag [WINDOW_DEPTH];

    packet_t  packet_queue [$];
    outcome_t outcome_queue [$];

    int packets_queued = 0;
    int packets_taken  = 0;
    int limit_writes   = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int quiet_cycles   = 0;
    bit pkt_taken      = 1'b0;

    // clock
    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    function automatic void clear_window();
        foreach (held_valid[i])
        begin
            held_valid[i] = 1'b0;
        end
        held_cnt = '0;
        head_idx = '0;
    endfunction

    function automatic void push_outcome(ev_t ev, logic [SEQ_W-1:0] seq,
                                         logic [TAG_W-1:0] tag);
        outcome_t o;
        o.ev   = ev;
        o.seq  = seq;
        o.tag  = tag;
        o.last = 1'b0;
        outcome_queue.push_back(o);
    endfunction

    // work out every result one accepted packet causes
    function automatic void predict_outcomes(logic [SEQ_W-1:0] seq, logic [TAG_W-1:0] tag);
        logic [SEQ_W-1:0] gap;
        logic [IDX_W-1:0] slot;
        outcome_t         tail;
        int               count;
        count = 0;
        gap   = seq - released_seq;
        slot  = IDX_W'(head_idx + gap - 16'd1);
        if (seq == '0)
        begin
            push_outcome(EV_HEADER, seq, tag);
            count++;
        end
        else if (!synced_q)
        begin
            // first data packet sets the baseline
            clear_window();
            synced_q     = 1'b1;
            released_seq = seq;
            push_outcome(EV_RELEASED, seq, tag);
            count++;
        end
        else if (gap == '0 || gap[SEQ_W-1])
        begin
            push_outcome(EV_LATE, seq, tag);
            count++;
        end
        else if (gap > WINDOW_DEPTH)
        begin
            push_outcome(EV_OUTSIDE, seq, tag);
            count++;
        end
        else if (gap == 16'd1)
        begin
            // next in line, then drain held packets in order
            push_outcome(EV_RELEASED, seq, tag);
            count++;
            released_seq = seq;
            head_idx++;
            while (count < WINDOW_DEPTH && held_valid[head_idx])
            begin
                released_seq++;
                push_outcome(EV_RELEASED, released_seq, held_tag[head_idx]);
                count++;
                held_valid[head_idx] = 1'b0;
                if (held_cnt > 0)
                    held_cnt--;
                head_idx++;
            end
        end
        else if (held_valid[slot])
        begin
            // duplicate of a held packet, the held one stays
            push_outcome(EV_LATE, seq, tag);
            count++;
        end
        else
        begin
            // early packet goes into the window
            held_valid[slot] = 1'b1;
            held_tag[slot]   = tag;
            held_cnt++;
            if (held_cnt > limit_q)
            begin
                clear_window();
                synced_q = 1'b0;
                push_outcome(EV_RESYNC, seq, tag);
                count++;
            end
        end
        if (count > 0)
        begin
            tail      = outcome_queue.pop_back();
            tail.last = 1'b1;
            outcome_queue.push_back(tail);
        end
    endfunction

    function automatic void check_field(string name, logic [SEQ_W-1:0] want,
                                        logic [SEQ_W-1:0] got);
        if (want !== got)
        begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // handshake monitor, prediction, result check and watchdog
    always @(posedge clk)
    begin
        outcome_t want;
        bit       moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (cfg.valid && cfg.ready)
            begin
                limit_q = cfg.hold_limit;
                limit_writes++;
                moved = 1'b1;
            end
            if (pkt.valid && pkt.ready)
            begin
                predict_outcomes(pkt.seq_number, pkt.payload_tag);
                packets_taken++;
                pkt_taken = 1'b1;
                moved     = 1'b1;
            end
            if (res.valid && res.ready)
            begin
                moved = 1'b1;
                if (outcome_queue.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("%0t: expected no result, got event %0d seq %0d tag %0d",
                                 $time, res.event_res, res.out_seq, res.out_tag);
                end
                else
                begin
                    want = outcome_queue.pop_front();
                    check_field("event_res", SEQ_W'(want.ev), SEQ_W'(res.event_res));
                    check_field("out_seq", want.seq, res.out_seq);
                    check_field("out_tag", want.tag, res.out_tag);
                    check_field("last", SEQ_W'(want.last), SEQ_W'(res.last));
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // packet driver and result back-pressure
    always @(negedge clk)
    begin
        packet_t next_pkt;
        if (rst_n)
        begin
            if (!pkt.valid || pkt_taken)
            begin
                if (packet_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_pkt = packet_queue.pop_front();
                    pkt.valid       <= 1'b1;
                    pkt.seq_number  <= next_pkt.seq;
                    pkt.payload_tag <= next_pkt.tag;
                end
                else
                begin
                    pkt.valid <= 1'b0;
                end
            end
            pkt_taken = 1'b0;
            res.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic queue_packet(logic [SEQ_W-1:0] seq, logic [TAG_W-1:0] tag);
        packet_t p;
        p.seq = seq;
        p.tag = tag;
        packet_queue.push_back(p);
        packets_queued++;
    endtask

    task automatic wait_sent();
        while (packets_taken != packets_queued)
            @(negedge clk);
    endtask

    // wait until the buffer has nothing left to say, plus its latency
    task automatic wait_idle();
        while (packets_taken != packets_queued || outcome_queue.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_limit(logic [LIM_W-1:0] value);
        int target;
        target = limit_writes + 1;
        cfg.valid      <= 1'b1;
        cfg.hold_limit <= value;
        @(negedge clk);
        while (limit_writes != target)
            @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // one stretch of consecutive packets from the predicted release point (a random start before
    // a baseline), often reordered, with stray packets mixed in
    task automatic queue_burst(output int added);
        logic [SEQ_W-1:0] start;
        logic [SEQ_W-1:0] order [$];
        logic [SEQ_W-1:0] swap;
        int               len;
        int               shape;
        int               pick;
        bit               backwards;
        if (synced_q)
            start = released_seq + 16'd1;
        else
            start = SEQ_W'($urandom_range(BASE_SEQ_MAX, 1));
        shape = $urandom_range(99);
        if (shape < 6)
            len = WINDOW_DEPTH;
        else if (shape < 30)
            len = $urandom_range(24, 2);
        else
            len = $urandom_range(8, 1);
        // full windows arrive backwards so the whole store drains at once
        backwards = (len == WINDOW_DEPTH) || ($urandom_range(4) == 0);
        for (int j = 0; j < len; j++)
        begin
            if (backwards)
                order.push_front(start + SEQ_W'(j));
            else
                order.push_back(start + SEQ_W'(j));
        end
        if (!backwards && $urandom_range(3) != 0)
        begin
            for (int j = len - 1; j > 0; j--)
            begin
                pick        = $urandom_range(j, 0);
                swap        = order[j];
                order[j]    = order[pick];
                order[pick] = swap;
            end
        end
        added = 0;
        foreach (order[j])
        begin
            if ($urandom_range(99) < NOISE_PCT)
            begin
                case ($urandom_range(3))
                    0: queue_packet('0, TAG_W'($urandom));
                    1: queue_packet(released_seq - SEQ_W'($urandom_range(40, 0)),
                                    TAG_W'($urandom));
                    2: queue_packet(released_seq + SEQ_W'($urandom_range(32800, 65)),
                                    TAG_W'($urandom));
                    default: queue_packet(order[j], TAG_W'($urandom));
                endcase
                added++;
            end
            queue_packet(order[j], TAG_W'($urandom));
            added++;
        end
    endtask

    task automatic run_phase(logic [LIM_W-1:0] limit, int mode, int count);
        int sent;
        int added;
        write_limit(limit);
        send_idle_pct  = SEND_IDLE[mode];
        recv_stall_pct = RECV_STALL[mode];
        sent = 0;
        while (sent < count)
        begin
            wait_sent();
            queue_burst(added);
            sent += added;
        end
        wait_idle();
    endtask

    // stimulus
    initial
    begin
        pkt.valid       = 1'b0;
        pkt.seq_number  = '0;
        pkt.payload_tag = '0;
        res.ready       = 1'b0;
        cfg.valid       = 1'b0;
        cfg.hold_limit  = '0;
        synced_q        = 1'b0;
        released_seq    = '0;
        limit_q         = HOLD_LIMIT_RESET;
        clear_window();

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // header before baseline, baseline, late, next, early, duplicate,
        // window edge, beyond window, half-range distance, drain
        queue_packet(16'd0, 16'hFFFF);
        queue_packet(16'd100, 16'h0000);
        queue_packet(16'd100, 16'h1111);
        queue_packet(16'd101, 16'hAAAA);
        queue_packet(16'd103, 16'h0003);
        queue_packet(16'd103, 16'h0004);
        queue_packet(16'd165, 16'h0005);
        queue_packet(16'd166, 16'h0006);
        queue_packet(16'd32868, 16'h0007);
        queue_packet(16'd32869, 16'h0008);
        queue_packet(16'd50, 16'h0009);
        queue_packet(16'd0, 16'h5A5A);
        queue_packet(16'd102, 16'h000B);
        queue_packet(16'd104, 16'h000C);
        wait_idle();

        // zero limit: any held packet resyncs, also across the wrap
        write_limit('0);
        queue_packet(16'd106, 16'h000D);
        queue_packet(16'hFFFF, 16'hFFFF);
        queue_packet(16'd1, 16'h000E);
        wait_idle();

        // release stalls after the top of the sequence space
        write_limit(LIM_W'(63));
        queue_packet(16'hFFFE, 16'h000F);
        queue_packet(16'd1, 16'h0010);
        queue_packet(16'hFFFF, 16'h0011);
        queue_packet(16'd1, 16'h0012);
        queue_packet(16'd2, 16'h0013);
        wait_idle();

        for (int p = 0; p < PHASE_COUNT; p++)
            run_phase(LIM_W'(PHASE_LIMIT[p]), p % 4, PHASE_ITEMS);

        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
